@@ sv/env_sensor_compensation_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sensor compensation core
// Two property forms: same-cycle and next-cycle implication, reset aware.
// ----------------------------------------------------------------------------
`ifndef ENV_SENSOR_COMPENSATION_CORE_DEFINES_SVH
`define ENV_SENSOR_COMPENSATION_CORE_DEFINES_SVH

// consequent must hold in the cycle of the antecedent
`define ESC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/esc_pkg.sv @@
// ----------------------------------------------------------------------------
// esc_pkg
// Types, constants and arithmetic helpers of the compensation pipeline.
// ----------------------------------------------------------------------------
package esc_pkg;

    // register indexes of the configuration port
    localparam logic [7:0] CFG_TEMP_CALIB  = 8'd0;
    localparam logic [7:0] CFG_PRESS_LOW   = 8'd1;
    localparam logic [7:0] CFG_PRESS_HIGH  = 8'd2;
    localparam logic [7:0] CFG_MIXED_CALIB = 8'd3;
    localparam logic [7:0] CFG_HUM_CALIB   = 8'd4;

    // pipeline depth: front end, divider, back end
    localparam int unsigned NPRE  = 14;
    localparam int unsigned NDIV  = 64;
    localparam int unsigned NPOST = 8;
    localparam int unsigned NST   = NPRE + NDIV + NPOST;

    // fixed-point constants of the compensation
    localparam logic [33:0] FINE_P_OFFS  = 34'd128000;
    localparam logic [20:0] P_FULL_SCALE = 21'd1048576;
    localparam logic [63:0] P_K3125      = 64'd3125;
    localparam logic [31:0] FINE_H_OFFS  = 32'd76800;
    localparam logic [31:0] H_RND_A      = 32'd16384;
    localparam logic [31:0] H_OFFS_C     = 32'd32768;
    localparam logic [31:0] H_OFFS_D     = 32'd2097152;
    localparam logic [31:0] H_RND_F      = 32'd8192;
    localparam logic [31:0] H_MAX        = 32'd419430400;
    localparam logic [31:0] T_RND        = 32'd128;
    localparam logic [63:0] P_BIAS       = 64'h0000_8000_0000_0000;
    // ceil(2^37 / 100): x / 100 == (x * RECIP_100) >> 37 for any 32-bit x
    localparam logic [30:0] RECIP_100    = 31'h51EB851F;

    // partial products of a 64 x 64 -> 64 (low half) multiply
    typedef struct packed {
        logic [63:0] lo;
        logic [31:0] c1;
        logic [31:0] c2;
    } t_pp;

    // fields that ride alongside the pressure path
    typedef struct packed {
        logic        fault;
        logic [31:0] temp;
        logic [6:0]  hum;
    } t_side;

    // magnitudes and sign ahead of the divider
    typedef struct packed {
        logic [63:0] na;
        logic [30:0] da;
        logic        neg;
    } t_dprep;

    // one divider stage
    typedef struct packed {
        logic [30:0] rem;
        logic [63:0] dq;
        logic [30:0] dvs;
        logic        neg;
        t_side       side;
    } t_div;

    function automatic t_pp pp64(input logic [63:0] x, input logic [63:0] y);
        t_pp r;
        r.lo = x[31:0] * y[31:0];
        r.c1 = x[31:0] * y[63:32];
        r.c2 = x[63:32] * y[31:0];
        return r;
    endfunction

    function automatic logic [63:0] sum64(input t_pp p);
        return p.lo + {p.c1 + p.c2, 32'd0};
    endfunction

    // one restoring step: dividend bits leave dq at the top, quotient bits enter
    function automatic t_div div_step(input t_div d);
        t_div        r;
        logic [31:0] t;
        r = d;
        t = {d.rem, d.dq[63]};
        if (t >= {1'b0, d.dvs}) begin
            r.rem = t[30:0] - d.dvs;
            r.dq  = {d.dq[62:0], 1'b1};
        end else begin
            r.rem = t[30:0];
            r.dq  = {d.dq[62:0], 1'b0};
        end
        return r;
    endfunction

endpackage

@@ sv/env_sensor_compensation_core.sv @@
// ----------------------------------------------------------------------------
// env_sensor_compensation_core
// Integer temperature, pressure and humidity compensation, fully pipelined.
// ----------------------------------------------------------------------------
// Use: a raw reading (pressure, temperature, humidity) is a request on the
// input channel (i_in_valid / o_in_ready); one compensated result leaves on
// the output channel (o_out_valid / i_out_ready) for each reading, in order.
// Calibration words are written on the config channel (i_cfg_valid, index,
// data); o_cfg_ready is always high. Write them only while no request is in
// flight: later stages read the calibration registers directly.
// Throughput: one request per cycle while o_in_ready is high. A result
// passes 14 front-end stages (fine temperature, 64-bit pressure products
// split into 32x32 partial products, the humidity chain), a 64-stage
// one-bit-per-stage signed divider, 8 back-end stages ending in a
// reciprocal multiply for the divide by 100, and the output register.
// Stall: the whole pipeline advances together; a skid register behind the
// output register catches the one result in transit, and o_in_ready drops
// (registered) while it is full. Nothing is lost or repeated.
// Reset (synchronous, active low) clears valid bits, the skid and the
// calibration registers; payload registers are not reset.
// Divisor zero gives pressure 0 and o_pressure_fault high.
// ----------------------------------------------------------------------------
`include "env_sensor_compensation_core_defines.svh"

module env_sensor_compensation_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // calibration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // raw readings
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [19:0] i_raw_pressure,
    input  logic [19:0] i_raw_temperature,
    input  logic [15:0] i_raw_humidity,
    // compensated results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_temperature_centi,
    output logic [25:0] o_pressure_hpa,
    output logic [6:0]  o_humidity_percent,
    output logic        o_pressure_fault
);
    import esc_pkg::*;

    // ------------------------------------------------------------------
    // Calibration registers
    // ------------------------------------------------------------------
    logic [47:0] r_temp_calib;
    logic [63:0] r_press_low;
    logic [63:0] r_press_high;
    logic [47:0] r_mixed_calib;
    logic [31:0] r_hum_calib;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_calib  <= '0;
            r_press_low   <= '0;
            r_press_high  <= '0;
            r_mixed_calib <= '0;
            r_hum_calib   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TEMP_CALIB:  r_temp_calib  <= i_cfg_data[47:0];
                CFG_PRESS_LOW:   r_press_low   <= i_cfg_data;
                CFG_PRESS_HIGH:  r_press_high  <= i_cfg_data;
                CFG_MIXED_CALIB: r_mixed_calib <= i_cfg_data[47:0];
                CFG_HUM_CALIB:   r_hum_calib   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // calibration words, sign or zero extended: 32 bits for the 32-bit paths,
    // 34 or 64 bits for the pressure path
    logic [15:0] t1;
    logic [31:0] t2_32, t3_32;
    logic [63:0] p1_64, p3_64, p4_64, p6_64, p7_64, p8_64, p9_64;
    logic [33:0] p2_s, p5_s;
    logic [31:0] h1_32, h2_32, h3_32, h4_hi, h5_32, h6_32;

    assign t1    = r_temp_calib[15:0];
    assign t2_32 = {{16{r_temp_calib[31]}}, r_temp_calib[31:16]};
    assign t3_32 = {{16{r_temp_calib[47]}}, r_temp_calib[47:32]};
    assign p1_64 = {48'd0, r_press_low[15:0]};
    assign p2_s  = {{18{r_press_low[31]}}, r_press_low[31:16]};
    assign p3_64 = {{48{r_press_low[47]}}, r_press_low[47:32]};
    assign p4_64 = {{48{r_press_low[63]}}, r_press_low[63:48]};
    assign p5_s  = {{18{r_press_high[15]}}, r_press_high[15:0]};
    assign p6_64 = {{48{r_press_high[31]}}, r_press_high[31:16]};
    assign p7_64 = {{48{r_press_high[47]}}, r_press_high[47:32]};
    assign p8_64 = {{48{r_press_high[63]}}, r_press_high[63:48]};
    assign p9_64 = {{48{r_mixed_calib[15]}}, r_mixed_calib[15:0]};
    assign h1_32 = {24'd0, r_mixed_calib[23:16]};
    assign h2_32 = {{16{r_mixed_calib[39]}}, r_mixed_calib[39:24]};
    assign h3_32 = {24'd0, r_mixed_calib[47:40]};
    assign h4_hi = {r_hum_calib[11:0], 20'd0};          // H4 * 2^20, wrapped
    assign h5_32 = {{20{r_hum_calib[23]}}, r_hum_calib[23:12]};
    assign h6_32 = {{24{r_hum_calib[31]}}, r_hum_calib[31:24]};

    // ------------------------------------------------------------------
    // Flow control: one enable for every stage, skid behind the output
    // ------------------------------------------------------------------
    logic           en;
    logic [NST-1:0] r_v;
    logic           r_out_v, r_skid_v;

    assign en         = !r_skid_v;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NST-2:0], i_in_valid};
        end
    end

    // ------------------------------------------------------------------
    // Front end, stages 1 to 14
    // ------------------------------------------------------------------
    // pass-through taps
    logic [19:0] r_adcp [8];     // stages 1..8
    logic [15:0] r_adch [4];     // stages 1..4
    logic [31:0] r_tc   [11];    // stages 4..14

    // stage 1: temperature products
    logic [31:0] n_x1, n_b0;
    logic [31:0] r_s1_ta, r_s1_sq;
    assign n_x1 = {15'd0, i_raw_temperature[19:3]} - {15'd0, t1, 1'b0};
    assign n_b0 = {16'd0, i_raw_temperature[19:4]} - {16'd0, t1};

    // stage 2
    logic [31:0] n_s2_a, n_bsq;
    logic [31:0] r_s2_a, r_s2_bt;
    assign n_s2_a = $signed(r_s1_ta) >>> 11;
    assign n_bsq  = $signed(r_s1_sq) >>> 12;

    // stage 3
    logic [31:0] n_bt14;
    logic [31:0] r_s3_fine;
    assign n_bt14 = $signed(r_s2_bt) >>> 14;

    // stage 4: temperature result, pressure and humidity offsets
    logic [31:0] n_t5, n_temp;
    logic [33:0] n_v1;
    logic [33:0] r_s4_v1;
    logic [31:0] r_s4_hv;
    assign n_t5   = r_s3_fine + {r_s3_fine[29:0], 2'b00} + T_RND;
    assign n_temp = $signed(n_t5) >>> 8;
    assign n_v1   = {{2{r_s3_fine[31]}}, r_s3_fine} - FINE_P_OFFS;

    // stage 5
    logic signed [67:0] n_sqf;
    logic signed [67:0] n_m5, n_m2;
    logic [63:0] r_s5_sq, r_s5_t5, r_s5_t2;
    logic [31:0] r_s5_h5v, r_s5_vh6, r_s5_vh3, r_s5_abase;
    assign n_sqf = $signed(r_s4_v1) * $signed(r_s4_v1);
    assign n_m5  = $signed(r_s4_v1) * $signed(p5_s);
    assign n_m2  = $signed(r_s4_v1) * $signed(p2_s);

    // stage 6
    logic [31:0] n_ha, n_hb1, n_vh3s;
    t_pp         r_s6_pp6, r_s6_pp3;
    logic [63:0] r_s6_t5, r_s6_t2;
    logic [31:0] r_s6_ha, r_s6_hb1, r_s6_hc;
    assign n_ha   = $signed(r_s5_abase - r_s5_h5v + H_RND_A) >>> 15;
    assign n_hb1  = $signed(r_s5_vh6) >>> 10;
    assign n_vh3s = $signed(r_s5_vh3) >>> 11;

    // stage 7
    logic [63:0] r_s7_sqp6, r_s7_sqp3, r_s7_t5, r_s7_t2;
    logic [31:0] r_s7_ha, r_s7_hbc;

    // stage 8
    logic [63:0] n_sqp3s;
    logic [31:0] n_hbc10;
    logic [63:0] r_s8_v2, r_s8_x;
    logic [31:0] r_s8_ha, r_s8_hbd;
    assign n_sqp3s = $signed(r_s7_sqp3) >>> 8;
    assign n_hbc10 = $signed(r_s7_hbc) >>> 10;

    // stage 9
    logic [20:0] n_pd;
    t_pp         r_s9_ppx;
    logic [63:0] r_s9_n0;
    logic [31:0] r_s9_ha, r_s9_hbe;
    assign n_pd = P_FULL_SCALE - {1'b0, r_adcp[7]};

    // stage 10
    logic [63:0] n_v1full;
    logic [31:0] n_hbf;
    logic [30:0] r_s10_v1c;
    t_pp         r_s10_ppn;
    logic [31:0] r_s10_ha, r_s10_hbf;
    assign n_v1full = sum64(r_s9_ppx);
    assign n_hbf    = $signed(r_s9_hbe + H_RND_F) >>> 14;

    // stage 11
    logic [63:0] r_s11_num;
    logic [30:0] r_s11_v1c;
    logic [31:0] r_s11_hv;

    // stage 12
    logic [31:0] n_a2;
    t_dprep      r_s12_dp;
    logic        r_s12_fault;
    logic [31:0] r_s12_hv, r_s12_hsq;
    assign n_a2 = $signed(r_s11_hv) >>> 15;

    // stage 13
    logic [31:0] n_hsq7;
    t_dprep      r_s13_dp;
    logic        r_s13_fault;
    logic [31:0] r_s13_hv, r_s13_ha3;
    assign n_hsq7 = $signed(r_s12_hsq) >>> 7;

    // stage 14: humidity finished and clamped
    logic [31:0] n_ha4, n_vf;
    logic [6:0]  n_hum;
    t_dprep      r_s14_dp;
    logic        r_s14_fault;
    logic [6:0]  r_s14_hum;
    assign n_ha4 = $signed(r_s13_ha3) >>> 4;
    assign n_vf  = r_s13_hv - n_ha4;

    always_comb begin
        if (n_vf[31]) begin
            n_hum = '0;
        end else if (n_vf > H_MAX) begin
            n_hum = H_MAX[28:22];
        end else begin
            n_hum = n_vf[28:22];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // taps
            r_adcp[0] <= i_raw_pressure;
            for (int k = 1; k < 8; k++) r_adcp[k] <= r_adcp[k-1];
            r_adch[0] <= i_raw_humidity;
            for (int k = 1; k < 4; k++) r_adch[k] <= r_adch[k-1];
            r_tc[0] <= n_temp;
            for (int k = 1; k < 11; k++) r_tc[k] <= r_tc[k-1];

            // 1
            r_s1_ta <= n_x1 * t2_32;
            r_s1_sq <= n_b0 * n_b0;
            // 2
            r_s2_a  <= n_s2_a;
            r_s2_bt <= n_bsq * t3_32;
            // 3
            r_s3_fine <= r_s2_a + n_bt14;
            // 4
            r_s4_v1 <= n_v1;
            r_s4_hv <= r_s3_fine - FINE_H_OFFS;
            // 5
            r_s5_sq    <= n_sqf[63:0];
            r_s5_t5    <= n_m5[63:0];
            r_s5_t2    <= n_m2[63:0];
            r_s5_h5v   <= h5_32 * r_s4_hv;
            r_s5_vh6   <= r_s4_hv * h6_32;
            r_s5_vh3   <= r_s4_hv * h3_32;
            r_s5_abase <= {2'b00, r_adch[3], 14'd0} - h4_hi;
            // 6
            r_s6_pp6 <= pp64(r_s5_sq, p6_64);
            r_s6_pp3 <= pp64(r_s5_sq, p3_64);
            r_s6_t5  <= r_s5_t5;
            r_s6_t2  <= r_s5_t2;
            r_s6_ha  <= n_ha;
            r_s6_hb1 <= n_hb1;
            r_s6_hc  <= n_vh3s + H_OFFS_C;
            // 7
            r_s7_sqp6 <= sum64(r_s6_pp6);
            r_s7_sqp3 <= sum64(r_s6_pp3);
            r_s7_t5   <= r_s6_t5;
            r_s7_t2   <= r_s6_t2;
            r_s7_ha   <= r_s6_ha;
            r_s7_hbc  <= r_s6_hb1 * r_s6_hc;
            // 8
            r_s8_v2  <= r_s7_sqp6 + {r_s7_t5[46:0], 17'd0} + {p4_64[28:0], 35'd0};
            r_s8_x   <= n_sqp3s + {r_s7_t2[51:0], 12'd0} + P_BIAS;
            r_s8_ha  <= r_s7_ha;
            r_s8_hbd <= n_hbc10 + H_OFFS_D;
            // 9
            r_s9_ppx <= pp64(r_s8_x, p1_64);
            r_s9_n0  <= {12'd0, n_pd, 31'd0} - r_s8_v2;
            r_s9_ha  <= r_s8_ha;
            r_s9_hbe <= r_s8_hbd * h2_32;
            // 10
            r_s10_v1c <= n_v1full[63:33];
            r_s10_ppn <= pp64(r_s9_n0, P_K3125);
            r_s10_ha  <= r_s9_ha;
            r_s10_hbf <= n_hbf;
            // 11
            r_s11_num <= sum64(r_s10_ppn);
            r_s11_v1c <= r_s10_v1c;
            r_s11_hv  <= r_s10_ha * r_s10_hbf;
            // 12: magnitudes for the divider
            r_s12_dp.na  <= r_s11_num[63] ? (64'd0 - r_s11_num) : r_s11_num;
            r_s12_dp.da  <= r_s11_v1c[30] ? (31'd0 - r_s11_v1c) : r_s11_v1c;
            r_s12_dp.neg <= r_s11_num[63] ^ r_s11_v1c[30];
            r_s12_fault  <= (r_s11_v1c == 31'd0);
            r_s12_hv     <= r_s11_hv;
            r_s12_hsq    <= n_a2 * n_a2;
            // 13
            r_s13_dp    <= r_s12_dp;
            r_s13_fault <= r_s12_fault;
            r_s13_hv    <= r_s12_hv;
            r_s13_ha3   <= n_hsq7 * h1_32;
            // 14
            r_s14_dp    <= r_s13_dp;
            r_s14_fault <= r_s13_fault;
            r_s14_hum   <= n_hum;
        end
    end

    // ------------------------------------------------------------------
    // Divider: one quotient bit per stage, magnitudes, sign applied after
    // ------------------------------------------------------------------
    t_div r_dv [NDIV];
    t_div n_dv0;

    always_comb begin
        n_dv0.rem        = '0;
        n_dv0.dq         = r_s14_dp.na;
        n_dv0.dvs        = r_s14_dp.da;
        n_dv0.neg        = r_s14_dp.neg;
        n_dv0.side.fault = r_s14_fault;
        n_dv0.side.temp  = r_tc[10];
        n_dv0.side.hum   = r_s14_hum;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0] <= div_step(n_dv0);
            for (int k = 1; k < NDIV; k++) r_dv[k] <= div_step(r_dv[k-1]);
        end
    end

    // ------------------------------------------------------------------
    // Back end, stages Q1 to Q8
    // ------------------------------------------------------------------
    t_side       r_qs [NPOST];
    logic [63:0] r_q1_p, r_q2_p, r_q3_p, r_q4_p, r_q5_p;
    t_pp         r_q2_ppaa, r_q2_pp8, r_q4_pp9;
    logic [63:0] r_q3_aa, r_q3_p8p, r_q4_v2x, r_q5_v1x, r_q5_v2x;
    logic [63:0] r_q6_s, r_q7_pp;
    logic [62:0] r_q8_prod;

    logic [63:0] n_qa, n_v2x, n_v1x, n_s8;
    assign n_qa  = $signed(r_q1_p) >>> 13;
    assign n_v2x = $signed(r_q3_p8p) >>> 19;
    assign n_v1x = $signed(sum64(r_q4_pp9)) >>> 25;
    assign n_s8  = $signed(r_q6_s) >>> 8;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qs[0] <= r_dv[NDIV-1].side;
            for (int k = 1; k < NPOST; k++) r_qs[k] <= r_qs[k-1];
            // Q1: signed quotient
            r_q1_p <= r_dv[NDIV-1].neg ? (64'd0 - r_dv[NDIV-1].dq) : r_dv[NDIV-1].dq;
            // Q2
            r_q2_ppaa <= pp64(n_qa, n_qa);
            r_q2_pp8  <= pp64(p8_64, r_q1_p);
            r_q2_p    <= r_q1_p;
            // Q3
            r_q3_aa  <= sum64(r_q2_ppaa);
            r_q3_p8p <= sum64(r_q2_pp8);
            r_q3_p   <= r_q2_p;
            // Q4
            r_q4_pp9 <= pp64(p9_64, r_q3_aa);
            r_q4_v2x <= n_v2x;
            r_q4_p   <= r_q3_p;
            // Q5
            r_q5_v1x <= n_v1x;
            r_q5_v2x <= r_q4_v2x;
            r_q5_p   <= r_q4_p;
            // Q6
            r_q6_s <= r_q5_p + r_q5_v1x + r_q5_v2x;
            // Q7
            r_q7_pp <= n_s8 + {p7_64[59:0], 4'd0};
            // Q8: divide by 100 through the reciprocal
            r_q8_prod <= r_q7_pp[39:8] * RECIP_100;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid
    // ------------------------------------------------------------------
    logic [31:0] n_last_temp;
    logic [25:0] n_last_press;
    logic [6:0]  n_last_hum;
    logic        n_last_fault;

    assign n_last_temp  = r_qs[NPOST-1].temp;
    assign n_last_hum   = r_qs[NPOST-1].hum;
    assign n_last_fault = r_qs[NPOST-1].fault;
    assign n_last_press = n_last_fault ? '0 : r_q8_prod[62:37];

    logic [31:0] r_out_temp, r_skid_temp;
    logic [25:0] r_out_press, r_skid_press;
    logic [6:0]  r_out_hum, r_skid_hum;
    logic        r_out_fault, r_skid_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (en) begin
            if (!r_out_v || i_out_ready) begin
                r_out_v     <= r_v[NST-1];
                r_out_temp  <= n_last_temp;
                r_out_press <= n_last_press;
                r_out_hum   <= n_last_hum;
                r_out_fault <= n_last_fault;
            end else if (r_v[NST-1]) begin
                // receiver stalled: park the result in transit
                r_skid_v     <= 1'b1;
                r_skid_temp  <= n_last_temp;
                r_skid_press <= n_last_press;
                r_skid_hum   <= n_last_hum;
                r_skid_fault <= n_last_fault;
            end
        end else if (i_out_ready) begin
            r_skid_v    <= 1'b0;
            r_out_temp  <= r_skid_temp;
            r_out_press <= r_skid_press;
            r_out_hum   <= r_skid_hum;
            r_out_fault <= r_skid_fault;
        end
    end

    assign o_out_valid         = r_out_v;
    assign o_temperature_centi = r_out_temp;
    assign o_pressure_hpa      = r_out_press;
    assign o_humidity_percent  = r_out_hum;
    assign o_pressure_fault    = r_out_fault;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ESC_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_in_valid && o_in_ready, r_v[0], "accepted request missing from stage 1")
    `ESC_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v, "skid full with output register empty")
    `ESC_ASSERT_NOW(a_skid_fill, i_clk, i_rst_n, $rose(r_skid_v), $past(r_out_v && !i_out_ready && r_v[NST-1]), "skid filled without a stalled result")
    `ESC_ASSERT_NOW(a_fault_zero, i_clk, i_rst_n, o_out_valid && o_pressure_fault, o_pressure_hpa == 26'd0, "pressure not zero on divisor fault")

endmodule

@@ sim/env_sensor_compensation_core_chk.sv @@
// ----------------------------------------------------------------------------
// Compensation checker
// Watches the calibration, reading and result channels, predicts each
// compensated result from its own copy of the calibration words and compares
// it field by field with what leaves the core.
// ----------------------------------------------------------------------------
module env_sensor_compensation_core_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [19:0] i_raw_pressure,
    input  logic [19:0] i_raw_temperature,
    input  logic [15:0] i_raw_humidity,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_temperature_centi,
    input  logic [25:0] i_pressure_hpa,
    input  logic [6:0]  i_humidity_percent,
    input  logic        i_pressure_fault,
    output int          o_fail_count,
    output int          o_pending
);
    import esc_pkg::*;

    typedef struct {
        logic [31:0] temp;
        logic [25:0] press;
        logic [6:0]  hum;
        logic        fault;
    } t_reading;

    logic [47:0] temp_cal;
    logic [63:0] press_lo_cal, press_hi_cal;
    logic [47:0] mixed_cal;
    logic [31:0] hum_cal;
    t_reading    awaited[$];

    // wrap to 32 bits, sign extended
    function automatic longint w32(input longint u);
        logic signed [31:0] t;
        t = u[31:0];
        return longint'(t);
    endfunction

    function automatic longint s16(input logic [15:0] x);
        return longint'($signed(x));
    endfunction

    function automatic t_reading compensate(input logic [19:0] rp, input logic [19:0] rt,
                                            input logic [15:0] rh);
        t_reading r;
        longint adc_p, adc_t, adc_h;
        longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint h1, h2, h3, h4, h5, h6;
        longint a, b, fine, v1, v2, p, num, v, q;
        logic [31:0] q32;
        adc_p = longint'({44'd0, rp});
        adc_t = longint'({44'd0, rt});
        adc_h = longint'({48'd0, rh});
        t1 = longint'({48'd0, temp_cal[15:0]});
        t2 = s16(temp_cal[31:16]);
        t3 = s16(temp_cal[47:32]);
        p1 = longint'({48'd0, press_lo_cal[15:0]});
        p2 = s16(press_lo_cal[31:16]);
        p3 = s16(press_lo_cal[47:32]);
        p4 = s16(press_lo_cal[63:48]);
        p5 = s16(press_hi_cal[15:0]);
        p6 = s16(press_hi_cal[31:16]);
        p7 = s16(press_hi_cal[47:32]);
        p8 = s16(press_hi_cal[63:48]);
        p9 = s16(mixed_cal[15:0]);
        h1 = longint'({56'd0, mixed_cal[23:16]});
        h2 = s16(mixed_cal[39:24]);
        h3 = longint'({56'd0, mixed_cal[47:40]});
        h4 = longint'($signed(hum_cal[11:0]));
        h5 = longint'($signed(hum_cal[23:12]));
        h6 = longint'($signed(hum_cal[31:24]));

        // temperature, 32-bit wrapping
        a = w32(((adc_t >>> 3) - t1 * 2) * t2) >>> 11;
        b = (adc_t >>> 4) - t1;
        b = w32((w32(b * b) >>> 12) * t3) >>> 14;
        fine = w32(a + b);
        r.temp = 32'(w32(w32(fine * 5) + 128) >>> 8);

        // pressure, 64-bit wrapping
        r.press = '0;
        r.fault = 1'b0;
        v1 = fine - 128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
        if (v1 == 0) begin
            r.fault = 1'b1;
        end else begin
            p   = 1048576 - adc_p;
            num = ((p <<< 31) - v2) * 3125;
            // divisor of minus one: plain wrapped negation
            if (v1 == -1) begin
                p = -num;
            end else begin
                p = num / v1;
            end
            a  = p >>> 13;
            v1 = (p9 * a * a) >>> 25;
            v2 = (p8 * p) >>> 19;
            p  = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
            q   = p >>> 8;
            q32 = q[31:0];
            r.press = 26'(q32 / 32'd100);
        end

        // humidity, 32-bit wrapping
        v = w32(fine - 76800);
        a = w32(w32(w32(adc_h <<< 14) - w32(h4 * 1048576)) - w32(h5 * v));
        a = w32(a + 16384) >>> 15;
        b = w32(v * h6) >>> 10;
        b = w32(b * w32((w32(v * h3) >>> 11) + 32768));
        b = w32((b >>> 10) + 2097152);
        b = w32(w32(b * h2) + 8192) >>> 14;
        v = w32(a * b);
        a = v >>> 15;
        a = w32((w32(a * a) >>> 7) * h1) >>> 4;
        v = w32(v - a);
        if (v < 0) v = 0;
        if (v > 419430400) v = 419430400;
        r.hum = 7'((v >>> 12) / 1024);
        return r;
    endfunction

    assign o_pending = awaited.size();

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            temp_cal     <= '0;
            press_lo_cal <= '0;
            press_hi_cal <= '0;
            mixed_cal    <= '0;
            hum_cal      <= '0;
            o_fail_count <= 0;
            awaited.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                awaited.push_back(compensate(i_raw_pressure, i_raw_temperature,
                                             i_raw_humidity));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TEMP_CALIB:  temp_cal     <= i_cfg_data[47:0];
                    CFG_PRESS_LOW:   press_lo_cal <= i_cfg_data;
                    CFG_PRESS_HIGH:  press_hi_cal <= i_cfg_data;
                    CFG_MIXED_CALIB: mixed_cal    <= i_cfg_data[47:0];
                    CFG_HUM_CALIB:   hum_cal      <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual t=%0d p=%0d h=%0d f=%0b",
                             $time, $signed(i_temperature_centi), i_pressure_hpa,
                             i_humidity_percent, i_pressure_fault);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = awaited.pop_front();
                    if (want.temp !== i_temperature_centi || want.press !== i_pressure_hpa ||
                        want.hum !== i_humidity_percent || want.fault !== i_pressure_fault) begin
                        $display("%0t: mismatch expected t=%0d p=%0d h=%0d f=%0b", $time,
                                 $signed(want.temp), want.press, want.hum, want.fault);
                        $display("%0t:          actual   t=%0d p=%0d h=%0d f=%0b", $time,
                                 $signed(i_temperature_centi), i_pressure_hpa,
                                 i_humidity_percent, i_pressure_fault);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ sim/env_sensor_compensation_core_tb.sv @@
// ----------------------------------------------------------------------------
// Compensation core testbench
// Drives raw readings and calibration sets into the core with random gaps on
// both channels; the checker beside it predicts and compares every result.
// ----------------------------------------------------------------------------
module env_sensor_compensation_core_tb;
    import esc_pkg::*;

    // an index past the last register: the write must be ignored
    localparam logic [7:0] CFG_UNUSED = 8'd5;
    // latency from the head of the core, plus margin
    localparam int DRAIN_CYCLES = NST + 20;

    logic        i_clk, i_rst_n;
    logic        i_cfg_valid, o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_in_valid, o_in_ready;
    logic [19:0] i_raw_pressure, i_raw_temperature;
    logic [15:0] i_raw_humidity;
    logic        o_out_valid, i_out_ready;
    logic [31:0] o_temperature_centi;
    logic [25:0] o_pressure_hpa;
    logic [6:0]  o_humidity_percent;
    logic        o_pressure_fault;
    int          fail_count, pending;
    bit          no_idle;   // set for a long stretch with no gaps on either side

    env_sensor_compensation_core dut (.*);

    env_sensor_compensation_core_chk chk (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready),
        .i_raw_pressure, .i_raw_temperature, .i_raw_humidity,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_temperature_centi(o_temperature_centi), .i_pressure_hpa(o_pressure_hpa),
        .i_humidity_percent(o_humidity_percent), .i_pressure_fault(o_pressure_fault),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result side back-pressure, ready low with a probability of about one in ten
    always @(negedge i_clk) begin
        i_out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 10);
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

    // one calibration request; called from the negedge
    task automatic write_cal(input logic [7:0] idx, input logic [63:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_cal(input logic [47:0] tc, input logic [63:0] pl,
                            input logic [63:0] ph, input logic [47:0] mc,
                            input logic [31:0] hc);
        write_cal(CFG_TEMP_CALIB, {$urandom, $urandom} & 64'hFFFF_0000_0000_0000 | tc);
        write_cal(CFG_PRESS_LOW, pl);
        write_cal(CFG_PRESS_HIGH, ph);
        write_cal(CFG_MIXED_CALIB, {16'hFFFF, mc});
        write_cal(CFG_HUM_CALIB, {$urandom, hc});
    endtask

    // one reading request, with an occasional gap ahead of it
    task automatic send_reading(input logic [19:0] rp, input logic [19:0] rt,
                                input logic [15:0] rh);
        while (!no_idle && $urandom_range(99) < 10) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        = 1'b1;
        i_raw_pressure    = rp;
        i_raw_temperature = rt;
        i_raw_humidity    = rh;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // let every result out, then idle for the pipeline depth
    task automatic drain;
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // typical readings: temperature and pressure near room conditions, with about one in four fully random
    task automatic send_typical(input int n);
        repeat (n) begin
            if ($urandom_range(3) == 0)
                send_reading(20'($urandom), 20'($urandom), 16'($urandom));
            else
                send_reading(20'($urandom_range(300000, 450000)),
                             20'($urandom_range(480000, 560000)),
                             16'($urandom_range(20000, 36000)));
        end
    endtask

    initial begin
        int k;
        no_idle     = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_raw_pressure    = '0;
        i_raw_temperature = '0;
        i_raw_humidity    = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset calibration: P1 of zero, so every reading is a divisor fault
        send_reading('0, '0, '0);
        send_reading('1, '1, '1);
        drain();

        // datasheet-like calibration set
        load_cal({16'hFC18, 16'd26435, 16'd27504},
                 {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                 {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                 {8'd0, 16'd362, 8'd75, 16'd6000},
                 {8'd30, 12'd50, 12'd313});
        write_cal(CFG_UNUSED, '1);
        send_reading('0, '0, '0);
        send_reading('1, '1, '1);
        send_reading('1, '0, '0);
        send_reading('0, '1, '1);
        send_reading('0, '0, '1);
        send_reading(20'd415148, 20'd519888, 16'd30000);
        send_reading(20'h55555, 20'hAAAAA, 16'h5555);
        send_reading(20'hAAAAA, 20'h55555, 16'hAAAA);
        send_reading(20'd1, 20'd1, 16'd1);
        send_reading(20'd300000, 20'd700000, 16'd60000);
        send_typical(800);
        drain();

        // extremes of every calibration field: all ones, then sign bits only in the signed fields
        load_cal('1, '1, '1, '1, '1);
        send_typical(100);
        drain();
        load_cal(48'h8000_8000_0000, 64'h8000_8000_8000_FFFF, 64'h8000_8000_8000_8000,
                 48'hFF80_00FF_8000, 32'h8080_0800);
        send_typical(100);
        drain();

        // random calibration sets; the fourth one runs without any idling
        for (k = 0; k < 6; k++) begin
            no_idle = (k == 3);
            load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                     {$urandom, $urandom}, 48'({$urandom, $urandom}), $urandom);
            // a small P1 in one set, to reach a zero divisor
            if (k == 4) write_cal(CFG_PRESS_LOW, {48'($urandom), 16'd1});
            send_typical(k == 3 ? 300 : 90);
            drain();
        end
        no_idle = 1'b0;

        // back to reset values, still faulting
        load_cal('0, '0, '0, '0, '0);
        send_typical(40);
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
